[sv/banked_framebuffer_pixel_access_assert.svh]
// Assertion macros used by the pixel access emitter.
// Each macro expects clk and arst_n in scope and is disabled while reset is applied.
`ifndef BANKED_FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH
`define BANKED_FRAMEBUFFER_PIXEL_ACCESS_ASSERT_SVH

// Same-cycle implication.
`define BFPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BFPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bfpa_pkg.sv]
`default_nettype none

package bfpa_pkg;

	// Bank window geometry.
	localparam int          WINDOW_BITS = 16;
	localparam logic [31:0] WMASK       = 32'((64'd1 << WINDOW_BITS) - 64'd1);

	// Longest access list of one request and the width of an index into it.
	localparam int MAX_ACC = 9;
	localparam int IDX_W   = $clog2(MAX_ACC + 1);

	// Access operation codes.
	localparam logic [2:0] OP_BANK  = 3'd0;
	localparam logic [2:0] OP_SEQ   = 3'd1;
	localparam logic [2:0] OP_GRA   = 3'd2;
	localparam logic [2:0] OP_WR    = 3'd3;
	localparam logic [2:0] OP_RD    = 3'd4;
	localparam logic [2:0] OP_LATCH = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PIXEL_MODE    = 3'd0;
	localparam logic [2:0] CFG_PLANE_X_MODE  = 3'd1;
	localparam logic [2:0] CFG_LINEAR_ENABLE = 3'd2;
	localparam logic [2:0] CFG_LINE_PITCH    = 3'd3;
	localparam logic [2:0] CFG_DRAW_COLOR    = 3'd4;

	// Pixel mode codes.
	localparam logic [2:0] PM_PLANAR = 3'd0;
	localparam logic [2:0] PM_BPP1   = 3'd1;
	localparam logic [2:0] PM_BPP2   = 3'd2;
	localparam logic [2:0] PM_BPP3   = 3'd3;
	localparam logic [2:0] PM_BPP4   = 3'd4;

	// Graphics and sequencer register indexes.
	localparam logic [31:0] SEQ_MAP_MASK = 32'h02;
	localparam logic [31:0] GRA_BIT_MASK = 32'h08;
	localparam logic [31:0] GRA_READ_MAP = 32'h04;

	typedef struct packed {
		logic        req_type;
		logic [12:0] pix_x;
		logic [12:0] pix_y;
	} req_t;

	typedef struct packed {
		logic [2:0]  access_op;
		logic [31:0] access_addr;
		logic [31:0] access_data;
		logic [2:0]  access_bytes;
		logic        last_access;
	} access_t;

	typedef access_t [MAX_ACC-1:0] access_list_t;

endpackage

`default_nettype wire

[sv/banked_framebuffer_pixel_access.sv]
// Channel   Handshake               Payload                 Direction
// request   start / busy            req (req_t)             in
// result    strobe                  result (access_t)       out
// config    cfg_valid / cfg_ready   cfg_index, cfg_data     in
//
// A request is taken when start is high and busy is low; it moves from stage one
// to stage two and then into the emitter, whose first result is on the port once it
// has loaded the list; the rest follow on consecutive cycles.
// A request produces zero to nine results; a request that produces none leaves the
// list stage without loading the emitter.
// The result port sets the sustained rate; the input and product stages overlap it.
// The receiver cannot stall; results appear for one cycle under strobe.
// Reset clears the pipeline and loads the register defaults.
`default_nettype none

module banked_framebuffer_pixel_access (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  bfpa_pkg::req_t      req,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [2:0]           cfg_index,
	input  wire [31:0]          cfg_data,
	output logic                strobe,
	output bfpa_pkg::access_t   result
);
	import bfpa_pkg::*;

	// Configuration registers.
	logic [2:0]  pixel_mode_q;
	logic        plane_x_mode_q;
	logic        linear_enable_q;
	logic [15:0] line_pitch_q;
	logic [31:0] draw_color_q;

	// Pipeline registers.
	logic        v_s1;
	req_t        req_s1;
	logic        v_s2;
	logic        rd_s2;
	logic [12:0] x_s2;
	logic [28:0] row_s2;

	logic         accept;
	logic         s1_adv;
	logic         s2_adv;
	logic         s2_free;
	logic         emit_done;
	logic         emit_load;
	access_list_t list;
	logic [IDX_W-1:0] cnt;

	// Stage flow control: each stage moves when the one after it empties.
	assign s2_free   = !v_s2 || emit_done;
	assign s2_adv    = v_s2 && emit_done;
	assign s1_adv    = v_s1 && s2_free;
	assign busy      = v_s1 && !s2_free;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign emit_load = s2_adv && (cnt != '0);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q    <= PM_BPP1;
			plane_x_mode_q  <= 1'b0;
			linear_enable_q <= 1'b0;
			line_pitch_q    <= 16'd640;
			draw_color_q    <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_MODE:    pixel_mode_q    <= cfg_data[2:0];
				CFG_PLANE_X_MODE:  plane_x_mode_q  <= cfg_data[0];
				CFG_LINEAR_ENABLE: linear_enable_q <= cfg_data[0];
				CFG_LINE_PITCH:    line_pitch_q    <= cfg_data[15:0];
				CFG_DRAW_COLOR:    draw_color_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2 <= 1'b1;
			end else if (s2_adv) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads; the row offset product is registered into stage two.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (s1_adv) begin
			rd_s2  <= req_s1.req_type;
			x_s2   <= req_s1.pix_x;
			row_s2 <= 29'(req_s1.pix_y) * 29'(line_pitch_q);
		end
	end

	function automatic access_t mk(logic [2:0] op, logic [31:0] addr, logic [31:0] data,
		logic [2:0] bytes);
		access_t a;
		a.access_op    = op;
		a.access_addr  = addr;
		a.access_data  = data;
		a.access_bytes = bytes;
		a.last_access  = 1'b0;
		return a;
	endfunction

	// Memory access: a write carries data, a read carries zero.
	function automatic access_t mem(logic rd, logic [31:0] addr, logic [31:0] data,
		logic [2:0] bytes);
		return mk(rd ? OP_RD : OP_WR, addr, rd ? 32'd0 : data, bytes);
	endfunction

	// Build the access list of the request in stage two.
	always_comb begin
		logic [31:0] row;
		logic [31:0] xterm;
		logic [31:0] off;
		logic [31:0] bank;
		logic [31:0] w;
		logic [31:0] b0;
		logic [31:0] b1;
		logic [31:0] b2;
		logic [31:0] lane;

		row  = 32'(row_s2);
		b0   = {24'd0, draw_color_q[7:0]};
		b1   = {24'd0, draw_color_q[15:8]};
		b2   = {24'd0, draw_color_q[23:16]};
		list = '0;
		cnt  = '0;

		// Column term of the byte offset for the active mode.
		if (plane_x_mode_q) begin
			xterm = 32'(x_s2[12:2]);
		end else begin
			case (pixel_mode_q)
				PM_PLANAR: xterm = 32'(x_s2[12:3]);
				PM_BPP2:   xterm = 32'({x_s2, 1'b0});
				PM_BPP3:   xterm = 32'({x_s2, 1'b0}) + 32'(x_s2);
				PM_BPP4:   xterm = 32'({x_s2, 2'b00});
				default:   xterm = 32'(x_s2);
			endcase
		end

		off  = row + xterm;
		bank = off >> WINDOW_BITS;
		w    = off & WMASK;

		case (pixel_mode_q)
			PM_BPP2: lane = 32'h0000_ffff;
			PM_BPP4: lane = 32'hffff_ffff;
			default: lane = 32'h0000_00ff;
		endcase

		if (plane_x_mode_q) begin
			// Mode-X: plane mask, then one byte.
			list[0] = mk(OP_SEQ, SEQ_MAP_MASK, 32'(4'b0001 << x_s2[1:0]), 3'd1);
			list[1] = mem(rd_s2, off, b0, 3'd1);
			cnt     = IDX_W'(2);
		end else if (pixel_mode_q == PM_PLANAR) begin
			list[0] = mk(OP_BANK, bank, 32'd0, 3'd1);
			if (!rd_s2) begin
				// Bit mask and latch read-modify-write.
				list[1] = mk(OP_GRA, GRA_BIT_MASK, 32'(8'h80 >> x_s2[2:0]), 3'd1);
				list[2] = mk(OP_LATCH, w, 32'd0, 3'd1);
				cnt     = IDX_W'(3);
			end else begin
				// One read per map, each after its map select.
				for (int i = 0; i < 4; i++) begin
					list[1 + 2 * i] = mk(OP_GRA, GRA_READ_MAP, 32'(i), 3'd1);
					list[2 + 2 * i] = mk(OP_RD, w, 32'd0, 3'd1);
				end
				cnt = IDX_W'(MAX_ACC);
			end
		end else if (pixel_mode_q == PM_BPP3) begin
			if (linear_enable_q) begin
				list[0] = mem(rd_s2, off, b0, 3'd1);
				list[1] = mem(rd_s2, off + 32'd1, b1, 3'd1);
				list[2] = mem(rd_s2, off + 32'd2, b2, 3'd1);
				cnt     = IDX_W'(3);
			end else begin
				list[0] = mk(OP_BANK, bank, 32'd0, 3'd1);
				if (w == WMASK - 32'd1) begin
					// Two bytes fit before the window edge.
					if (rd_s2) begin
						list[1] = mk(OP_RD, w, 32'd0, 3'd2);
						list[2] = mk(OP_BANK, bank + 32'd1, 32'd0, 3'd1);
						list[3] = mk(OP_RD, 32'd0, 32'd0, 3'd1);
						cnt     = IDX_W'(4);
					end else begin
						list[1] = mk(OP_WR, w, b0, 3'd1);
						list[2] = mk(OP_WR, w + 32'd1, b1, 3'd1);
						list[3] = mk(OP_BANK, bank + 32'd1, 32'd0, 3'd1);
						list[4] = mk(OP_WR, 32'd0, b2, 3'd1);
						cnt     = IDX_W'(5);
					end
				end else if (w == WMASK) begin
					// One byte fits before the window edge.
					list[1] = mem(rd_s2, w, b0, 3'd1);
					list[2] = mk(OP_BANK, bank + 32'd1, 32'd0, 3'd1);
					if (rd_s2) begin
						list[3] = mk(OP_RD, 32'd0, 32'd0, 3'd2);
						cnt     = IDX_W'(4);
					end else begin
						list[3] = mk(OP_WR, 32'd0, b1, 3'd1);
						list[4] = mk(OP_WR, 32'd1, b2, 3'd1);
						cnt     = IDX_W'(5);
					end
				end else if (rd_s2) begin
					list[1] = mk(OP_RD, w, 32'd0, 3'd2);
					list[2] = mk(OP_RD, w + 32'd2, 32'd0, 3'd1);
					cnt     = IDX_W'(3);
				end else begin
					list[1] = mk(OP_WR, w, b0, 3'd1);
					list[2] = mk(OP_WR, w + 32'd1, b1, 3'd1);
					list[3] = mk(OP_WR, w + 32'd2, b2, 3'd1);
					cnt     = IDX_W'(4);
				end
			end
		end else if (pixel_mode_q inside {PM_BPP1, PM_BPP2, PM_BPP4}) begin
			// Whole pixel in one access.
			if (linear_enable_q) begin
				list[0] = mem(rd_s2, off, draw_color_q & lane, pixel_mode_q);
				cnt     = IDX_W'(1);
			end else begin
				list[0] = mk(OP_BANK, bank, 32'd0, 3'd1);
				list[1] = mem(rd_s2, w, draw_color_q & lane, pixel_mode_q);
				cnt     = IDX_W'(2);
			end
		end
	end

	// Result sequencer.
	bfpa_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit_load),
		.list   (list),
		.cnt    (cnt),
		.done   (emit_done),
		.strobe (strobe),
		.result (result)
	);

endmodule

`default_nettype wire

[sv/bfpa_emitter.sv]
`default_nettype none

// Holds the access list of one request and plays it out one result per cycle.
module bfpa_emitter (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         load,
	input  bfpa_pkg::access_list_t      list,
	input  wire [bfpa_pkg::IDX_W-1:0]   cnt,
	output logic                        done,
	output logic                        strobe,
	output bfpa_pkg::access_t           result
);
	import bfpa_pkg::*;

	`include "banked_framebuffer_pixel_access_assert.svh"

	access_list_t     list_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             act_q;
	logic             last;

	// The current entry is the final one of its request.
	assign last = (idx_q == (cnt_q - IDX_W'(1)));

	// The list can be replaced when idle or once its final result is on the port.
	assign done   = !act_q || last;
	assign strobe = act_q;

	always_comb begin
		result             = list_q[idx_q];
		result.last_access = last;
	end

	// Control: active flag and position in the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			idx_q <= '0;
		end else if (act_q) begin
			if (last) begin
				act_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Payload: the list and its length.
	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= list;
			cnt_q  <= cnt;
		end
	end

	`BFPA_ASSERT_NOW(a_load_when_done, load, done, "list loaded while results still pending")
	`BFPA_ASSERT_NOW(a_idx_in_range, act_q, idx_q < cnt_q, "result index past list length")
	`BFPA_ASSERT_NEXT(a_load_starts, load, act_q && (idx_q == '0), "load did not start list")
	`BFPA_ASSERT_NEXT(a_no_gap, act_q && !last, act_q, "result sequence broken before last")
	`BFPA_ASSERT_NEXT(a_stop_after_last, act_q && last && !load, !act_q,
		"result strobe continued after last access")

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import bfpa_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_READ = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        strobe;
	access_t     result;

	// Local copy of the register file, updated on each configuration transfer.
	logic [2:0]  pixel_mode_q = PM_BPP1;
	logic        plane_x_q = 1'b0;
	logic        linear_q = 1'b0;
	logic [15:0] pitch_q = 16'd640;
	logic [31:0] color_q = 32'd0;

	req_t        pending_reqs[$];
	access_t     expected_accesses[$];
	access_t     plan_buf[0:MAX_ACC-1];
	int          plan_len;

	int gap_max = 12;
	int gap_left = 0;
	int stall_cycles = 0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;
	int setting_count = 0;

	banked_framebuffer_pixel_access DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result)
	);

	always #5 clk = ~clk;

	// Append one access to the plan of the current request.
	function automatic void put(input logic [2:0] op, input logic [31:0] addr,
			input logic [31:0] data, input logic [2:0] nbytes);
		plan_buf[plan_len] = '{access_op: op, access_addr: addr, access_data: data,
			access_bytes: nbytes, last_access: 1'b0};
		plan_len++;
	endfunction

	// Memory access: reads always carry zero data.
	function automatic void put_mem(input logic rd, input logic [31:0] addr,
			input logic [31:0] data, input logic [2:0] nbytes);
		put(rd ? OP_RD : OP_WR, addr, rd ? 32'd0 : data, nbytes);
	endfunction

	// Work out the access sequence of one request and queue it as expected.
	function automatic void plan_accesses(input req_t r);
		logic        rd;
		logic [31:0] x, y, row, off, w, bank, col, lanes;
		int          i;
		rd  = r.req_type;
		x   = {19'd0, r.pix_x};
		y   = {19'd0, r.pix_y};
		row = y * {16'd0, pitch_q};
		col = color_q;
		plan_len = 0;
		if (plane_x_q) begin
			put(OP_SEQ, SEQ_MAP_MASK, 32'd1 << x[1:0], 3'd1);
			put_mem(rd, row + (x >> 2), {24'd0, col[7:0]}, 3'd1);
		end else if (pixel_mode_q == PM_PLANAR) begin
			// Planar mode always goes through the bank window.
			off = row + (x >> 3);
			w = off & WMASK;
			put(OP_BANK, off >> WINDOW_BITS, 32'd0, 3'd1);
			if (!rd) begin
				put(OP_GRA, GRA_BIT_MASK, 32'h80 >> x[2:0], 3'd1);
				put(OP_LATCH, w, 32'd0, 3'd1);
			end else begin
				for (i = 0; i < 4; i++) begin
					put(OP_GRA, GRA_READ_MAP, 32'(i), 3'd1);
					put(OP_RD, w, 32'd0, 3'd1);
				end
			end
		end else if (pixel_mode_q == PM_BPP3) begin
			off = row + x * 32'd3;
			if (linear_q) begin
				for (i = 0; i < 3; i++)
					put_mem(rd, off + 32'(i), (col >> (8 * i)) & 32'hff, 3'd1);
			end else begin
				bank = off >> WINDOW_BITS;
				w = off & WMASK;
				put(OP_BANK, bank, 32'd0, 3'd1);
				if (w == WMASK - 32'd1) begin
					// Two bytes below the window edge, the third in the next bank.
					if (rd) begin
						put_mem(1'b1, w, 32'd0, 3'd2);
					end else begin
						put_mem(1'b0, w, {24'd0, col[7:0]}, 3'd1);
						put_mem(1'b0, w + 32'd1, {24'd0, col[15:8]}, 3'd1);
					end
					put(OP_BANK, bank + 32'd1, 32'd0, 3'd1);
					put_mem(rd, 32'd0, {24'd0, col[23:16]}, 3'd1);
				end else if (w == WMASK) begin
					// One byte below the edge, two in the next bank.
					put_mem(rd, w, {24'd0, col[7:0]}, 3'd1);
					put(OP_BANK, bank + 32'd1, 32'd0, 3'd1);
					if (rd) begin
						put_mem(1'b1, 32'd0, 32'd0, 3'd2);
					end else begin
						put_mem(1'b0, 32'd0, {24'd0, col[15:8]}, 3'd1);
						put_mem(1'b0, 32'd1, {24'd0, col[23:16]}, 3'd1);
					end
				end else if (rd) begin
					put_mem(1'b1, w, 32'd0, 3'd2);
					put_mem(1'b1, w + 32'd2, 32'd0, 3'd1);
				end else begin
					for (i = 0; i < 3; i++)
						put_mem(1'b0, w + 32'(i), (col >> (8 * i)) & 32'hff, 3'd1);
				end
			end
		end else if (pixel_mode_q == PM_BPP1 || pixel_mode_q == PM_BPP2 ||
				pixel_mode_q == PM_BPP4) begin
			off = row + x * {29'd0, pixel_mode_q};
			lanes = (pixel_mode_q == PM_BPP4) ? 32'hffff_ffff :
				((32'd1 << (8 * pixel_mode_q)) - 32'd1);
			if (!linear_q)
				put(OP_BANK, off >> WINDOW_BITS, 32'd0, 3'd1);
			put_mem(rd, linear_q ? off : (off & WMASK), col & lanes, pixel_mode_q);
		end
		// Unused pixel modes produce no access at all.
		if (plan_len > 0)
			plan_buf[plan_len - 1].last_access = 1'b1;
		for (i = 0; i < plan_len; i++)
			expected_accesses.push_back(plan_buf[i]);
	endfunction

	// Coordinate biased toward the ends of its range.
	function automatic logic [12:0] coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 13'd8191 : 13'd0;
		return 13'($urandom_range(0, 8191));
	endfunction

	// Random request; in banked three-byte mode it often lands on the window edge.
	function automatic req_t random_request();
		req_t        r;
		logic [31:0] target, rem;
		int          tries;
		r.req_type = 1'($urandom_range(0, 1));
		r.pix_x = coord();
		r.pix_y = coord();
		if (!plane_x_q && pixel_mode_q == PM_BPP3 && !linear_q && $urandom_range(0, 2) == 0) begin
			target = WMASK - 32'($urandom_range(0, 1));
			for (tries = 0; tries < 64; tries++) begin
				r.pix_y = 13'($urandom_range(0, 8191));
				rem = (target - {19'd0, r.pix_y} * {16'd0, pitch_q}) & WMASK;
				if (rem % 3 == 0 && rem / 3 < 8192) begin
					r.pix_x = 13'(rem / 3);
					break;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Request driver: waits a random gap, presents the next queued request and
	// predicts its accesses on each transfer.
	always @(posedge clk) begin : request_driver
		if (arst_n) begin
			if (start && !busy) begin
				plan_accesses(req);
				sent_count++;
			end
			if (start && busy) begin
				// Hold the request until it is taken.
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
				gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: every strobed access must match the oldest expectation.
	always @(posedge clk) begin : access_monitor
		access_t want;
		if (arst_n && strobe) begin
			if (expected_accesses.size() == 0) begin
				$error("unexpected access: op %0d addr %0h data %0h",
					result.access_op, result.access_addr, result.access_data);
				mismatch_count++;
			end else begin
				want = expected_accesses.pop_front();
				check_field("access_op", 32'(want.access_op), 32'(result.access_op));
				check_field("access_addr", want.access_addr, result.access_addr);
				check_field("access_data", want.access_data, result.access_data);
				check_field("access_bytes", 32'(want.access_bytes), 32'(result.access_bytes));
				check_field("last_access", 32'(want.last_access), 32'(result.last_access));
				checked_count++;
			end
		end
	end

	// Watchdog: ends the run when no request or register transfer happens for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// One register write transfer; the local copy follows it.
	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PIXEL_MODE:    pixel_mode_q = value[2:0];
			CFG_PLANE_X_MODE:  plane_x_q = value[0];
			CFG_LINEAR_ENABLE: linear_q = value[0];
			CFG_LINE_PITCH:    pitch_q = value[15:0];
			CFG_DRAW_COLOR:    color_q = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic request_pixel(input logic kind, input int x, input int y);
		pending_reqs.push_back('{req_type: kind, pix_x: 13'(x), pix_y: 13'(y)});
	endtask

	// Sender holds off until every expected access is in and the pipeline is quiet.
	task automatic settle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_accesses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		setting_count++;
	endtask

	initial begin : stimulus
		logic [2:0] pm;
		logic       px;
		int         counted, phase, n, k;
		logic       live;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: one byte per pixel, banked.
		request_pixel(REQ_DRAW, 0, 0);
		request_pixel(REQ_READ, 8191, 8191);
		settle();

		// Mode-X: every plane, widest pitch, all-ones colour.
		set_reg(CFG_PLANE_X_MODE, 32'd1);
		set_reg(CFG_DRAW_COLOR, 32'hffff_ffff);
		set_reg(CFG_LINE_PITCH, 32'd65535);
		request_pixel(REQ_DRAW, 0, 0);
		request_pixel(REQ_DRAW, 1, 8191);
		request_pixel(REQ_DRAW, 2, 100);
		request_pixel(REQ_DRAW, 3, 1);
		request_pixel(REQ_READ, 8191, 8191);
		settle();

		// Planar mode ignores the linear flag; zero pitch.
		set_reg(CFG_PLANE_X_MODE, 32'd0);
		set_reg(CFG_PIXEL_MODE, {29'd0, PM_PLANAR});
		set_reg(CFG_LINEAR_ENABLE, 32'd1);
		set_reg(CFG_LINE_PITCH, 32'd0);
		request_pixel(REQ_DRAW, 0, 0);
		request_pixel(REQ_DRAW, 8191, 77);
		request_pixel(REQ_READ, 5, 8191);
		settle();

		// Three bytes banked: pixels that straddle the window edge either way, and one that does not.
		set_reg(CFG_PIXEL_MODE, {29'd0, PM_BPP3});
		set_reg(CFG_LINEAR_ENABLE, 32'd0);
		set_reg(CFG_LINE_PITCH, 32'd65535);
		set_reg(CFG_DRAW_COLOR, 32'h00a5_c35a);
		request_pixel(REQ_DRAW, 0, 2);
		request_pixel(REQ_READ, 0, 2);
		request_pixel(REQ_DRAW, 0, 1);
		request_pixel(REQ_READ, 0, 1);
		request_pixel(REQ_DRAW, 1, 0);
		request_pixel(REQ_READ, 1, 0);
		settle();

		// Three bytes linear.
		set_reg(CFG_LINEAR_ENABLE, 32'd1);
		request_pixel(REQ_DRAW, 8191, 8191);
		request_pixel(REQ_READ, 100, 3);
		settle();

		// Two bytes linear, then four bytes banked.
		set_reg(CFG_PIXEL_MODE, {29'd0, PM_BPP2});
		request_pixel(REQ_DRAW, 4000, 5);
		settle();
		set_reg(CFG_PIXEL_MODE, {29'd0, PM_BPP4});
		set_reg(CFG_LINEAR_ENABLE, 32'd0);
		request_pixel(REQ_READ, 8191, 8191);
		settle();

		// Unused pixel modes: requests are taken but cause no access.
		set_reg(CFG_PIXEL_MODE, 32'd7);
		request_pixel(REQ_DRAW, 1, 1);
		settle();
		set_reg(CFG_PIXEL_MODE, 32'd5);
		request_pixel(REQ_READ, 2, 2);
		settle();

		// Random settings, each followed by a batch of random requests.
		counted = 0;
		phase = 0;
		while (counted < RANDOM_ITEMS) begin
			px = ($urandom_range(0, 3) == 0);
			pm = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(0, 4));
			live = px || (pm <= PM_BPP4);
			set_reg(CFG_PIXEL_MODE, {29'd0, pm});
			set_reg(CFG_PLANE_X_MODE, {31'd0, px});
			set_reg(CFG_LINEAR_ENABLE, 32'($urandom_range(0, 1)));
			case ($urandom_range(0, 4))
				0: set_reg(CFG_LINE_PITCH, 32'd0);
				1: set_reg(CFG_LINE_PITCH, 32'd65535);
				2: set_reg(CFG_LINE_PITCH, 32'd640);
				default: set_reg(CFG_LINE_PITCH, 32'($urandom_range(0, 65535)));
			endcase
			case ($urandom_range(0, 3))
				0: set_reg(CFG_DRAW_COLOR, 32'd0);
				1: set_reg(CFG_DRAW_COLOR, 32'hffff_ffff);
				default: set_reg(CFG_DRAW_COLOR, $urandom);
			endcase
			// Every third batch runs back to back with no sender gaps.
			gap_max = (phase % 3 == 1) ? 0 : 12;
			n = live ? 25 : 3;
			for (k = 0; k < n; k++)
				pending_reqs.push_back(random_request());
			if (live)
				counted += n;
			settle();
			phase++;
		end

		$display("summary: %0d requests over %0d register settings, %0d accesses compared",
			sent_count, setting_count, checked_count);
		$display("summary: %0d mismatches", mismatch_count);
		if (mismatch_count == 0 && expected_accesses.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
